/* design/eht_pkg.sv */
// ----------------------------------------------------------------------------
// eht_pkg: shared types and constants of the entity handle table
// Command and status codes, payload structs and the scanner control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eht_pkg;

  // Default sizing
  localparam int unsigned SLOTS_DEF      = 64;
  localparam int unsigned COMP_TYPES_DEF = 4;

  // Fixed field widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned TYPE_W   = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned HANDLE_W = 6;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE  = 3'd0,
    CMD_DESTROY = 3'd1,
    CMD_VALID   = 3'd2,
    CMD_ADD     = 3'd3,
    CMD_REMOVE  = 3'd4,
    CMD_HAS     = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_UNKNOWN  = 2'd2,
    STAT_BAD_TYPE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN
  } state_e;

  // Command payload
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   entity_id;
    logic [TYPE_W-1:0] comp_type;
  } req_t;

  // Result payload
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     new_id;
    logic [HANDLE_W-1:0] slot_handle;
    logic                flag;
    logic [COUNT_W-1:0]  live_count;
  } rsp_t;

  // Scanner control
  typedef struct packed {
    logic            start;
    logic            find_free;
    logic [ID_W-1:0] entity_id;
  } scan_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_rsp_t;

endpackage

`default_nettype wire

/* design/eht_ram.sv */
// ----------------------------------------------------------------------------
// eht_ram: slot table memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eht_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 37,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

/* design/eht_scan.sv */
// ----------------------------------------------------------------------------
// eht_scan: slot table scanner
// Walks the table from slot 0, one read a cycle, and stops at the first free
// slot or live slot with the requested identifier, else at the last slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eht_scan
  import eht_pkg::*;
#(
  parameter int unsigned SLOTS      = SLOTS_DEF,
  parameter int unsigned COMP_TYPES = COMP_TYPES_DEF,
  parameter int unsigned AW         = $clog2(SLOTS),
  parameter int unsigned DW         = 1 + ID_W + COMP_TYPES
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire scan_req_t     scan_req_i,
  output scan_rsp_t          scan_rsp_o,
  output logic [AW-1:0]      slot_o,
  output logic               rd_en_o,
  output logic [AW-1:0]      rd_addr_o,
  input  wire logic [DW-1:0] rd_data_i
);

  localparam logic [AW-1:0] LastAddr = AW'(SLOTS - 1);

  logic            active_q, active_d;
  logic            chk_q, chk_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic [AW-1:0]   chk_addr_q, chk_addr_d;
  logic            free_q, free_d;
  logic [ID_W-1:0] id_q, id_d;

  logic            ent_live;
  logic [ID_W-1:0] ent_ident;
  logic            match;
  logic            done;

  // Compare the entry read in the last cycle
  assign ent_live  = rd_data_i[DW-1];
  assign ent_ident = rd_data_i[DW-2 -: ID_W];
  assign match     = free_q ? !ent_live : (ent_live && (ent_ident == id_q));
  assign done      = chk_q && (match || (chk_addr_q == LastAddr));

  assign scan_rsp_o.done = done;
  assign scan_rsp_o.hit  = chk_q && match;
  assign slot_o          = chk_addr_q;
  assign rd_en_o         = active_q;
  assign rd_addr_o       = addr_q;

  // Advance the read address, stop on the first hit or after the last slot
  always_comb begin
    active_d   = active_q;
    addr_d     = addr_q;
    chk_d      = 1'b0;
    chk_addr_d = addr_q;
    free_d     = free_q;
    id_d       = id_q;
    if (scan_req_i.start) begin
      active_d = 1'b1;
      addr_d   = '0;
      free_d   = scan_req_i.find_free;
      id_d     = scan_req_i.entity_id;
    end else begin
      chk_d = active_q && !done;
      if (done) begin
        active_d = 1'b0;
      end else if (active_q) begin
        if (addr_q == LastAddr) begin
          active_d = 1'b0;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      chk_q    <= 1'b0;
    end else begin
      active_q <= active_d;
      chk_q    <= chk_d;
    end
  end

  // Hold scan address and key
  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    chk_addr_q <= chk_addr_d;
    free_q     <= free_d;
    id_q       <= id_d;
  end

endmodule

`default_nettype wire

/* design/entity_handle_table.sv */
// ----------------------------------------------------------------------------
// entity_handle_table: slot allocator for live entities
// Create, destroy, query and component presence commands over a slot table.
// ----------------------------------------------------------------------------
// Usage:
//   A command (req_i) is taken at a rising edge with start high and busy low.
//   Its one result appears on rsp_o for exactly one cycle with done_o high;
//   the receiver cannot stall it, so it must take it in that cycle.
//   The table lives in one memory of SLOTS entries {live, ident, components}.
//   Create, destroy, query and the component commands scan it from slot 0,
//   one entry a cycle; those that change the found entry write it back in
//   the cycle the scan ends. Create on a full table and unused command
//   codes answer without a scan. Results are registered and show in the
//   cycle after the command's last cycle.
//   After reset a clearing pass marks every slot free, one slot a cycle;
//   busy stays high until it ends. The identifier counter restarts at one
//   and the live count at zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module entity_handle_table
  import eht_pkg::*;
#(
  parameter int unsigned SLOTS      = SLOTS_DEF,
  parameter int unsigned COMP_TYPES = COMP_TYPES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      done_o,
  output rsp_t      rsp_o
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned DW = 1 + ID_W + COMP_TYPES;
  localparam logic [AW-1:0] LastAddr = AW'(SLOTS - 1);

  state_e          state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [ID_W-1:0] ctr_q, ctr_d;
  req_t            req_q, req_d;
  rsp_t            res_q, res_d;
  logic            res_vld_q, res_vld_d;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [DW-1:0]   wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [DW-1:0]   rd_data;

  scan_req_t       scan_req;
  scan_rsp_t       scan_rsp;
  logic [AW-1:0]   scan_slot;

  logic [COMP_TYPES-1:0] comp_mask;
  logic [COMP_TYPES-1:0] ent_comp;
  logic                  type_ok;
  logic [ID_W-1:0]       ctr_inc;

  eht_ram #(
    .DEPTH (SLOTS),
    .WIDTH (DW),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  eht_scan #(
    .SLOTS      (SLOTS),
    .COMP_TYPES (COMP_TYPES),
    .AW         (AW),
    .DW         (DW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .scan_req_i (scan_req),
    .scan_rsp_o (scan_rsp),
    .slot_o     (scan_slot),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data)
  );

  // Decode the component type into a one-hot mask
  always_comb begin
    for (int j = 0; j < COMP_TYPES; j++) begin
      comp_mask[j] = (req_q.comp_type == TYPE_W'(j));
    end
  end

  assign type_ok  = {1'b0, req_q.comp_type} < (TYPE_W + 1)'(COMP_TYPES);
  assign ent_comp = rd_data[COMP_TYPES-1:0];
  assign ctr_inc  = ctr_q + 1'b1;

  assign busy   = (state_q != ST_IDLE);
  assign done_o = res_vld_q;
  assign rsp_o  = res_q;

  // Sequence clearing, command issue, and write-back at the end of a scan
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cnt_d     = cnt_q;
    ctr_d     = ctr_q;
    req_d     = req_q;
    res_d     = res_q;
    res_vld_d = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = scan_slot;
    wr_data   = '0;
    scan_req  = '0;

    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        if (clr_q == LastAddr) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (start) begin
          req_d                = req_i;
          res_d.status         = STAT_OK;
          res_d.new_id         = '0;
          res_d.slot_handle    = '0;
          res_d.flag           = 1'b0;
          res_d.live_count     = COUNT_W'(cnt_q);
          scan_req.entity_id   = req_i.entity_id;
          scan_req.find_free   = (req_i.cmd == CMD_CREATE);
          unique case (req_i.cmd) inside
            CMD_CREATE: begin
              if (cnt_q >= CW'(SLOTS)) begin
                res_d.status = STAT_FULL;
                res_vld_d    = 1'b1;
              end else begin
                scan_req.start = 1'b1;
                state_d        = ST_SCAN;
              end
            end
            CMD_DESTROY, CMD_VALID, CMD_ADD, CMD_REMOVE, CMD_HAS: begin
              scan_req.start = 1'b1;
              state_d        = ST_SCAN;
            end
            default: begin
              res_vld_d = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (scan_rsp.done) begin
          state_d   = ST_IDLE;
          res_vld_d = 1'b1;
          if (!scan_rsp.hit) begin
            res_d.status = (req_q.cmd == CMD_CREATE) ? STAT_FULL : STAT_UNKNOWN;
          end else begin
            unique case (req_q.cmd) inside
              CMD_CREATE: begin
                wr_en             = 1'b1;
                wr_data           = {1'b1, ctr_q, {COMP_TYPES{1'b0}}};
                res_d.new_id      = ctr_q;
                res_d.slot_handle = HANDLE_W'(scan_slot);
                ctr_d             = (ctr_inc == '0) ? ID_W'(1) : ctr_inc;
                cnt_d             = cnt_q + 1'b1;
              end
              CMD_DESTROY: begin
                wr_en             = 1'b1;
                wr_data           = {1'b0, {ID_W{1'b0}}, ent_comp};
                res_d.slot_handle = HANDLE_W'(scan_slot);
                if (cnt_q != '0) begin
                  cnt_d = cnt_q - 1'b1;
                end
              end
              CMD_VALID: begin
                res_d.flag        = 1'b1;
                res_d.slot_handle = HANDLE_W'(scan_slot);
              end
              CMD_ADD, CMD_REMOVE, CMD_HAS: begin
                if (!type_ok) begin
                  res_d.status = STAT_BAD_TYPE;
                end else begin
                  res_d.slot_handle = HANDLE_W'(scan_slot);
                  if (req_q.cmd == CMD_ADD) begin
                    wr_en      = 1'b1;
                    wr_data    = {rd_data[DW-1:COMP_TYPES], ent_comp | comp_mask};
                    res_d.flag = |(ent_comp & comp_mask);
                  end else if (req_q.cmd == CMD_REMOVE) begin
                    wr_en   = 1'b1;
                    wr_data = {rd_data[DW-1:COMP_TYPES], ent_comp & ~comp_mask};
                  end else begin
                    res_d.flag = |(ent_comp & comp_mask);
                  end
                end
              end
              default: begin
                res_d.status = STAT_OK;
              end
            endcase
          end
          res_d.live_count = COUNT_W'(cnt_d);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      cnt_q     <= '0;
      ctr_q     <= ID_W'(1);
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      cnt_q     <= cnt_d;
      ctr_q     <= ctr_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Hold command and result payload
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(SLOTS))
    else $error("live count exceeds table size");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("accepted command neither answered nor in progress");

  a_write_on_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && state_q == ST_SCAN) |-> scan_rsp.done)
    else $error("table write outside the end of a scan");

  a_scan_in_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_rsp.done |-> (state_q == ST_SCAN))
    else $error("scan finished while no command in progress");

  a_fail_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != STAT_OK) |-> (rsp_o.slot_handle == '0 && rsp_o.new_id == '0))
    else $error("failed command returned a handle or identifier");
`endif

endmodule

`default_nettype wire

/* tb/entity_handle_table_checker.sv */
// ----------------------------------------------------------------------------
// entity_handle_table_checker: result predictor and scoreboard
// Watches command and result transfers of the entity handle table, keeps its
// own copy of the slot table and compares every result, field by field,
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module entity_handle_table_checker
  import eht_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  req_t        req_i,
  input  logic        done_o,
  input  rsp_t        rsp_o,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // Shadow slot table
  logic [ID_W-1:0]           slot_ident [SLOTS_DEF];
  logic                      slot_live  [SLOTS_DEF];
  logic [COMP_TYPES_DEF-1:0] comp_bits  [SLOTS_DEF];
  logic [ID_W-1:0]           id_counter;
  logic [COUNT_W-1:0]        live_total;

  rsp_t        awaited_rsp_q[$];
  rsp_t        oldest_rsp;
  int unsigned mismatch_total = 0;

  assign fail_count_o = mismatch_total;

  task automatic report_mismatch(string field, logic [ID_W-1:0] got, logic [ID_W-1:0] want);
    $display("%0t: %s mismatch: got 0x%0h, predicted 0x%0h", $time, field, got, want);
    mismatch_total++;
  endtask

  task automatic clear_slots();
    for (int i = 0; i < SLOTS_DEF; i++) begin
      slot_ident[i] = '0;
      slot_live[i]  = 1'b0;
      comp_bits[i]  = '0;
    end
    id_counter = ID_W'(1);
    live_total = '0;
  endtask

  // Apply one command to the shadow table and return its result
  function automatic rsp_t predict_table(req_t r);
    rsp_t                      res;
    int                        found;
    logic [COMP_TYPES_DEF-1:0] mask;
    res   = '0;
    found = -1;
    if (r.cmd == CMD_CREATE) begin
      if (live_total < SLOTS_DEF) begin
        // Take the lowest free slot
        for (int i = 0; i < SLOTS_DEF; i++) begin
          if (!slot_live[i] && found < 0) found = i;
        end
        res.new_id      = id_counter;
        res.slot_handle = found[HANDLE_W-1:0];
        slot_ident[found] = id_counter;
        slot_live[found]  = 1'b1;
        comp_bits[found]  = '0;
        live_total++;
        // Advance the identifier, never handing out zero
        id_counter++;
        if (id_counter == '0) id_counter = ID_W'(1);
      end else begin
        res.status = STAT_FULL;
      end
    end else if (r.cmd <= CMD_HAS) begin
      // Lowest live slot holding the identifier; zero never matches
      if (r.entity_id != '0) begin
        for (int i = 0; i < SLOTS_DEF; i++) begin
          if (found < 0 && slot_live[i] && slot_ident[i] == r.entity_id) found = i;
        end
      end
      if (found < 0) begin
        res.status = STAT_UNKNOWN;
      end else if (r.cmd == CMD_DESTROY) begin
        slot_ident[found] = '0;
        slot_live[found]  = 1'b0;
        live_total--;
        res.slot_handle = found[HANDLE_W-1:0];
      end else if (r.cmd == CMD_VALID) begin
        res.flag        = 1'b1;
        res.slot_handle = found[HANDLE_W-1:0];
      end else if (r.comp_type >= COMP_TYPES_DEF) begin
        res.status = STAT_BAD_TYPE;
      end else begin
        mask                 = '0;
        mask[r.comp_type]    = 1'b1;
        res.slot_handle      = found[HANDLE_W-1:0];
        if (r.cmd == CMD_ADD) begin
          res.flag         = |(comp_bits[found] & mask);
          comp_bits[found] = comp_bits[found] | mask;
        end else if (r.cmd == CMD_REMOVE) begin
          comp_bits[found] = comp_bits[found] & ~mask;
        end else begin
          res.flag = |(comp_bits[found] & mask);
        end
      end
    end
    res.live_count = live_total;
    return res;
  endfunction

  // Retire results against the oldest prediction, then queue new ones
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_slots();
      awaited_rsp_q.delete();
      pending_o <= 0;
    end else begin
      if (done_o) begin
        if (awaited_rsp_q.size() == 0) begin
          report_mismatch("unexpected result, status", rsp_o.status, '0);
        end else begin
          oldest_rsp = awaited_rsp_q.pop_front();
          if (rsp_o.status !== oldest_rsp.status)
            report_mismatch("status", rsp_o.status, oldest_rsp.status);
          if (rsp_o.new_id !== oldest_rsp.new_id)
            report_mismatch("new_id", rsp_o.new_id, oldest_rsp.new_id);
          if (rsp_o.slot_handle !== oldest_rsp.slot_handle)
            report_mismatch("slot_handle", rsp_o.slot_handle, oldest_rsp.slot_handle);
          if (rsp_o.flag !== oldest_rsp.flag)
            report_mismatch("flag", rsp_o.flag, oldest_rsp.flag);
          if (rsp_o.live_count !== oldest_rsp.live_count)
            report_mismatch("live_count", rsp_o.live_count, oldest_rsp.live_count);
        end
      end
      if (start && !busy) begin
        awaited_rsp_q.push_back(predict_table(req_i));
      end
      pending_o <= awaited_rsp_q.size();
    end
  end

endmodule

/* tb/entity_handle_table_tb.sv */
// ----------------------------------------------------------------------------
// entity_handle_table_tb: testbench top of the entity handle table
// Runs a directed pass over every command and corner case, then random
// fill, churn and drain phases with random sender gaps. The checker beside
// the block predicts and compares; this module only drives and judges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module entity_handle_table_tb;
  import eht_pkg::*;

  localparam int unsigned       WATCHDOG_LIMIT = 2000;
  localparam int unsigned       RANDOM_BLOCKS  = 15;
  localparam int unsigned       BLOCK_ITEMS    = 100;
  localparam logic [CMD_W-1:0]  CMD_SPARE_LO   = 3'd6;
  localparam logic [CMD_W-1:0]  CMD_SPARE_HI   = 3'd7;
  localparam logic [TYPE_W-1:0] TYPE_LAST      = TYPE_W'(COMP_TYPES_DEF - 1);
  localparam logic [TYPE_W-1:0] TYPE_FIRST_BAD = TYPE_W'(COMP_TYPES_DEF);

  typedef enum int unsigned {
    MIX_FILL,
    MIX_CHURN,
    MIX_DRAIN
  } mix_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start  = 1'b0;
  logic        busy;
  req_t        req    = '0;
  logic        done_o;
  rsp_t        rsp_o;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned creates_sent = 0;
  int unsigned idle_cycles  = 0;

  always #4 clk_i = ~clk_i;

  entity_handle_table i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  entity_handle_table_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req),
    .done_o       (done_o),
    .rsp_o        (rsp_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Abort when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold a command until the block takes it
  task automatic issue_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                               logic [TYPE_W-1:0] ty);
    req_t cmd_req;
    cmd_req.cmd       = cmd;
    cmd_req.entity_id = id;
    cmd_req.comp_type = ty;
    if (cmd == CMD_CREATE) creates_sent++;
    start <= 1'b1;
    req   <= cmd_req;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start and wait until every predicted result has arrived
  task automatic wait_all_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Random sender gap with junk on the request bus
  task automatic pause_sender();
    int unsigned roll;
    int unsigned gap;
    req_t        junk;
    roll = $urandom_range(0, 99);
    if (roll < 50)      gap = 0;
    else if (roll < 85) gap = $urandom_range(1, 3);
    else if (roll < 97) gap = $urandom_range(4, 12);
    else                gap = $urandom_range(20, 60);
    if (gap != 0) begin
      junk.cmd       = CMD_W'($urandom());
      junk.entity_id = $urandom();
      junk.comp_type = TYPE_W'($urandom());
      start <= 1'b0;
      req   <= junk;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Mostly recently issued identifiers, some zero, some anything
  function automatic logic [ID_W-1:0] pick_entity_id();
    int unsigned roll;
    int unsigned lo;
    roll = $urandom_range(0, 99);
    lo   = (creates_sent > 90) ? creates_sent - 90 : 1;
    if (roll < 5)  return '0;
    if (roll < 12) return $urandom();
    return $urandom_range(lo, creates_sent + 1);
  endfunction

  task automatic random_command(mix_e mix);
    int unsigned       roll;
    int unsigned       sub;
    int unsigned       create_pct;
    int unsigned       destroy_pct;
    logic [CMD_W-1:0]  cmd;
    logic [TYPE_W-1:0] ty;
    case (mix)
      MIX_FILL: begin
        create_pct  = 75;
        destroy_pct = 5;
      end
      MIX_DRAIN: begin
        create_pct  = 5;
        destroy_pct = 60;
      end
      default: begin
        create_pct  = 25;
        destroy_pct = 20;
      end
    endcase
    roll = $urandom_range(0, 99);
    sub  = $urandom_range(0, 19);
    if (roll < create_pct)                    cmd = CMD_CREATE;
    else if (roll < create_pct + destroy_pct) cmd = CMD_DESTROY;
    else if (sub < 4)                         cmd = CMD_VALID;
    else if (sub < 9)                         cmd = CMD_ADD;
    else if (sub < 12)                        cmd = CMD_REMOVE;
    else if (sub < 18)                        cmd = CMD_HAS;
    else if (sub == 18)                       cmd = CMD_SPARE_LO;
    else                                      cmd = CMD_SPARE_HI;
    // Mostly legal component types, sometimes any code
    ty = TYPE_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, COMP_TYPES_DEF - 1)
                                              : $urandom_range(0, 15));
    issue_command(cmd, (cmd == CMD_CREATE) ? $urandom() : pick_entity_id(), ty);
  endtask

  initial begin
    mix_e mix;
    bit   quiet;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: three entities in slots 0 to 2 with identifiers 1 to 3
    issue_command(CMD_CREATE, '0, '0);
    issue_command(CMD_CREATE, '1, '1);
    issue_command(CMD_CREATE, 32'h5555_AAAA, 4'd3);
    // Invalid identifiers and a live one
    issue_command(CMD_VALID, '0, '0);
    issue_command(CMD_VALID, '1, '0);
    issue_command(CMD_VALID, 32'd2, '0);
    // Component presence on entity 1
    issue_command(CMD_ADD, 32'd1, 4'd0);
    issue_command(CMD_ADD, 32'd1, 4'd0);
    issue_command(CMD_ADD, 32'd1, TYPE_LAST);
    issue_command(CMD_ADD, 32'd1, TYPE_FIRST_BAD);
    issue_command(CMD_HAS, 32'd1, 4'd15);
    issue_command(CMD_HAS, 32'd1, TYPE_LAST);
    issue_command(CMD_HAS, 32'd1, 4'd1);
    issue_command(CMD_REMOVE, 32'd1, 4'd1);
    issue_command(CMD_REMOVE, 32'd1, 4'd0);
    issue_command(CMD_HAS, 32'd1, 4'd0);
    // Unknown entity wins over a bad type
    issue_command(CMD_ADD, 32'd99, 4'd15);
    // Destroy, then reuse of slot 0 must start with no components
    issue_command(CMD_DESTROY, 32'd1, '0);
    issue_command(CMD_VALID, 32'd1, '0);
    issue_command(CMD_DESTROY, 32'd1, '0);
    issue_command(CMD_CREATE, '0, '0);
    issue_command(CMD_HAS, 32'd4, TYPE_LAST);
    issue_command(CMD_REMOVE, 32'd4, 4'd2);
    // Unused command codes
    issue_command(CMD_SPARE_LO, 32'd2, 4'd1);
    issue_command(CMD_SPARE_HI, 32'd3, 4'd2);
    wait_all_results();

    // Random: start by filling the table, then mixed phases
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      mix   = (blk < 2) ? MIX_FILL : mix_e'($urandom_range(0, 2));
      quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        random_command(mix);
        if ($urandom_range(0, 49) == 0) wait_all_results();
        else if (!quiet)                pause_sender();
      end
    end

    // Drain and allow for a last full scan
    wait_all_results();
    repeat (SLOTS_DEF + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
